FILE: rtl/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property with a reset that disables checking.
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition that must never be seen outside of reset.
`define ASSERT_NEVER(lbl, clk, rst, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

FILE: rtl/ildf_pkg.sv
// ----------------------------------------------------------------------------
// ildf_pkg
// Types and constants of the id/length message deframer.
// ----------------------------------------------------------------------------
package ildf_pkg;

  localparam int unsigned CFG_INDEX_W = 8;

  localparam logic [CFG_INDEX_W-1:0] REG_MAX_MESSAGE_ID     = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_PAYLOAD_LENGTH = 8'd1;

  localparam logic [15:0] MAX_MESSAGE_ID_RESET     = 16'd2048;
  localparam logic [15:0] MAX_PAYLOAD_LENGTH_RESET = 16'd2048;

  // Header bytes gathered before the final one.
  localparam logic [1:0] HEADER_LAST_COUNT = 2'd3;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_EMPTY   = 2'd1,
    KIND_ERROR   = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] message_id;
    logic [15:0] payload_length;
    logic [7:0]  data_byte;
    logic        last_of_message;
  } result_t;

  typedef struct packed {
    logic                   valid;
    logic [CFG_INDEX_W-1:0] index;
    logic [15:0]            data;
  } cfg_write_t;

endpackage

FILE: rtl/ildf_fifo.sv
// ----------------------------------------------------------------------------
// ildf_fifo
// Short result queue between the header parser and the output stage.
// ----------------------------------------------------------------------------
module ildf_fifo #(
  parameter int unsigned DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_en,
  input  ildf_pkg::result_t wr_data,
  output logic              full,
  input  logic              rd_en,
  output ildf_pkg::result_t rd_data,
  output logic              not_empty
);

  localparam int unsigned PtrW = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  ildf_pkg::result_t entries [DEPTH];
  logic [PtrW-1:0]   wr_ptr;
  logic [PtrW-1:0]   rd_ptr;
  logic [CntW-1:0]   count;
  logic              do_wr;
  logic              do_rd;

  assign full      = (count == FullCnt);
  assign not_empty = (count != '0);
  assign do_wr     = wr_en && !full;
  assign do_rd     = rd_en && not_empty;
  assign rd_data   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: rtl/ildf_front.sv
// ----------------------------------------------------------------------------
// ildf_front
// Header parser: gathers the 4-byte header, checks the limits and tags bytes.
// ----------------------------------------------------------------------------
module ildf_front (
  input  logic                 clk,
  input  logic                 rst,
  input  ildf_pkg::cfg_write_t cfg,
  input  logic                 byte_valid,
  input  logic [7:0]           in_byte,
  output logic                 res_valid,
  output ildf_pkg::result_t    res
);

  logic [15:0] max_message_id;
  logic [15:0] max_payload_length;

  logic [1:0]  header_count;
  logic [23:0] header_bytes;
  logic        in_payload;
  logic [15:0] held_id;
  logic [15:0] held_length;
  logic [15:0] bytes_left;
  logic        error_stop;

  logic [1:0]  header_count_next;
  logic [23:0] header_bytes_next;
  logic        in_payload_next;
  logic [15:0] held_id_next;
  logic [15:0] held_length_next;
  logic [15:0] bytes_left_next;
  logic        error_stop_next;

  logic [15:0] new_id;
  logic [15:0] new_length;
  logic        last_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_message_id     <= ildf_pkg::MAX_MESSAGE_ID_RESET;
      max_payload_length <= ildf_pkg::MAX_PAYLOAD_LENGTH_RESET;
    end else if (cfg.valid) begin
      if (cfg.index == ildf_pkg::REG_MAX_MESSAGE_ID) begin
        max_message_id <= cfg.data;
      end else if (cfg.index == ildf_pkg::REG_MAX_PAYLOAD_LENGTH) begin
        max_payload_length <= cfg.data;
      end
    end
  end

  assign new_id     = header_bytes[23:8];
  assign new_length = {header_bytes[7:0], in_byte};
  assign last_byte  = (bytes_left <= 16'd1);

  always_comb begin
    header_count_next = header_count;
    header_bytes_next = header_bytes;
    in_payload_next   = in_payload;
    held_id_next      = held_id;
    held_length_next  = held_length;
    bytes_left_next   = bytes_left;
    error_stop_next   = error_stop;
    res_valid         = 1'b0;
    res.kind            = ildf_pkg::KIND_PAYLOAD;
    res.message_id      = held_id;
    res.payload_length  = held_length;
    res.data_byte       = 8'd0;
    res.last_of_message = 1'b0;

    if (byte_valid && !error_stop) begin
      if (in_payload) begin
        res_valid           = 1'b1;
        res.data_byte       = in_byte;
        res.last_of_message = last_byte;
        if (last_byte) begin
          in_payload_next = 1'b0;
          bytes_left_next = 16'd0;
        end else begin
          bytes_left_next = bytes_left - 16'd1;
        end
      end else if (header_count != ildf_pkg::HEADER_LAST_COUNT) begin
        header_bytes_next = {header_bytes[15:0], in_byte};
        header_count_next = header_count + 2'd1;
      end else begin
        // The final header byte decides between error, empty message and payload.
        header_count_next  = 2'd0;
        header_bytes_next  = 24'd0;
        held_id_next       = new_id;
        held_length_next   = new_length;
        res.message_id     = new_id;
        res.payload_length = new_length;
        priority if (new_id > max_message_id || new_length > max_payload_length) begin
          res_valid       = 1'b1;
          res.kind        = ildf_pkg::KIND_ERROR;
          error_stop_next = 1'b1;
        end else if (new_length == 16'd0) begin
          res_valid           = 1'b1;
          res.kind            = ildf_pkg::KIND_EMPTY;
          res.last_of_message = 1'b1;
        end else begin
          in_payload_next = 1'b1;
          bytes_left_next = new_length;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      header_count <= 2'd0;
      header_bytes <= 24'd0;
      in_payload   <= 1'b0;
      held_id      <= 16'd0;
      held_length  <= 16'd0;
      bytes_left   <= 16'd0;
      error_stop   <= 1'b0;
    end else begin
      header_count <= header_count_next;
      header_bytes <= header_bytes_next;
      in_payload   <= in_payload_next;
      held_id      <= held_id_next;
      held_length  <= held_length_next;
      bytes_left   <= bytes_left_next;
      error_stop   <= error_stop_next;
    end
  end

endmodule

FILE: rtl/ildf_back.sv
// ----------------------------------------------------------------------------
// ildf_back
// Output register that presents the oldest queued result to the consumer.
// ----------------------------------------------------------------------------
module ildf_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_not_empty,
  input  ildf_pkg::result_t q_data,
  output logic              q_rd,
  input  logic              pop,
  output logic              out_valid,
  output ildf_pkg::result_t out_data
);

  // Refill whenever the register is free or is being drained this cycle.
  assign q_rd = q_not_empty && (!out_valid || pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_rd) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_rd) begin
      out_data <= q_data;
    end
  end

endmodule

FILE: rtl/id_length_message_deframer_top.sv
// ----------------------------------------------------------------------------
// id_length_message_deframer_top
// Splits a byte stream into messages with a 16-bit id and 16-bit length header.
// ----------------------------------------------------------------------------
// The deframer takes one byte per clock while full is low. Full stays low as
// long as the result queue (QUEUE_DEPTH entries) has room, so with pop held
// high it never stalls. A result enters the queue at the edge that accepts the
// byte that caused it, then moves to the output register once that register is
// free or being popped. The first three header bytes give no result. The fourth
// gives one only for an empty message or a framing error. After a framing error
// the block drops all bytes until reset. Limit registers are written through
// the cfg port, which is always ready. A new limit applies to the next completed header.
module id_length_message_deframer_top #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_byte,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  kind,
  output logic [15:0] message_id,
  output logic [15:0] payload_length,
  output logic [7:0]  data_byte,
  output logic        last_of_message,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [ildf_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [15:0] cfg_data
);

  ildf_pkg::cfg_write_t cfg;
  ildf_pkg::result_t    front_res;
  ildf_pkg::result_t    q_data;
  ildf_pkg::result_t    out_data;
  logic                 front_valid;
  logic                 q_full;
  logic                 q_not_empty;
  logic                 q_rd;
  logic                 out_valid;
  logic                 accept;

  assign cfg_ready = 1'b1;
  assign cfg.valid = cfg_valid;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  assign full   = q_full;
  assign accept = push && !q_full;

  ildf_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .byte_valid (accept),
    .in_byte    (in_byte),
    .res_valid  (front_valid),
    .res        (front_res)
  );

  ildf_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (front_valid),
    .wr_data   (front_res),
    .full      (q_full),
    .rd_en     (q_rd),
    .rd_data   (q_data),
    .not_empty (q_not_empty)
  );

  ildf_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_not_empty (q_not_empty),
    .q_data      (q_data),
    .q_rd        (q_rd),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_data    (out_data)
  );

  assign empty           = !out_valid;
  assign kind            = out_data.kind;
  assign message_id      = out_data.message_id;
  assign payload_length  = out_data.payload_length;
  assign data_byte       = out_data.data_byte;
  assign last_of_message = out_data.last_of_message;

endmodule

FILE: rtl/ildf_checker.sv
// ----------------------------------------------------------------------------
// ildf_checker
// Port-level checks on the results of the message deframer.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ildf_checker (
  input logic        clk,
  input logic        rst,
  input logic        empty,
  input logic        pop,
  input logic [1:0]  kind,
  input logic [15:0] message_id,
  input logic [15:0] payload_length,
  input logic [7:0]  data_byte,
  input logic        last_of_message
);

  `ASSERT_NEVER(a_kind_code, clk, rst, !empty && kind != ildf_pkg::KIND_PAYLOAD && kind != ildf_pkg::KIND_EMPTY && kind != ildf_pkg::KIND_ERROR, "result kind holds an unused code")

  `ASSERT_CLK(a_error_fields, clk, rst, (!empty && kind == ildf_pkg::KIND_ERROR) |-> (data_byte == 8'd0 && !last_of_message), "framing error result carries data or a last mark")

  `ASSERT_CLK(a_empty_fields, clk, rst, (!empty && kind == ildf_pkg::KIND_EMPTY) |-> (payload_length == 16'd0 && data_byte == 8'd0 && last_of_message), "empty message result is malformed")

  `ASSERT_CLK(a_hold_stalled, clk, rst, (!empty && !pop) |=> (!empty && $stable(kind) && $stable(message_id) && $stable(payload_length) && $stable(data_byte) && $stable(last_of_message)), "stalled result changed before transfer")

endmodule

bind id_length_message_deframer_top ildf_checker u_checker (.*);
